[rtl/assert_macros.svh]
// Assertion macros shared by the frame parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/cfcp_pkg.sv]
// Types, constants and codes of the camera frame checksum parser.
`timescale 1ns / 1ps

package cfcp_pkg;

  // Frame layout
  localparam int FRAME_SIZE    = 11;
  localparam int BUFFER_LENGTH = 16;
  localparam logic [7:0] HEADER_MARK  = 8'haa;
  localparam logic [7:0] TRAILER_MARK = 8'hee;

  // Input kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_IDLE = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FRAMING  = 2'd1;
  localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

  typedef logic [7:0] byte_t;

  // One result item
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] x_value;
    logic [15:0] y_value;
    logic [15:0] box_width;
    logic [15:0] box_length;
  } result_t;

endpackage

[rtl/camera_frame_checksum_parser.sv]
// Top level of the camera frame checksum parser: input and result registers.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// One input transfer per cycle is taken, byte or idle alike, while in_stall is low. A byte
// causes no result; an idle event produces one result, registered first in the input register
// and then in the result register. The frame
// check is a single 8-byte adder and compare between those two registers.
// in_stall rises only when an idle event is held in the input register and
// the result register still holds a result that has not been taken.
module camera_frame_checksum_parser import cfcp_pkg::*; #(
  parameter int BufferLength = BUFFER_LENGTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_x_value,
  output logic [15:0] out_y_value,
  output logic [15:0] out_box_width,
  output logic [15:0] out_box_length
);

  logic    s1_valid_r;
  logic    s1_kind_r;
  byte_t   s1_byte_r;
  logic    out_free;
  logic    s1_adv;
  result_t result;
  result_t out_r;
  logic    out_valid_r;

  // Handshake: an idle event needs room in the result register
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (s1_kind_r == KIND_BYTE || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
    end
  end

  cfcp_frame_check #(
    .BufferLength(BufferLength)
  ) u_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (s1_adv),
    .kind    (s1_kind_r),
    .rx_byte (s1_byte_r),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_kind_r == KIND_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_adv && s1_kind_r == KIND_IDLE) begin
      out_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_x_value    = out_r.x_value;
  assign out_y_value    = out_r.y_value;
  assign out_box_width  = out_r.box_width;
  assign out_box_length = out_r.box_length;

  `ASSERT_CLK_ALWAYS(a_stall_on_idle, in_stall |-> s1_valid_r && s1_kind_r == KIND_IDLE, "stall without a held idle event")
  `ASSERT_CLK(a_idle_gives_result, s1_adv && s1_kind_r == KIND_IDLE |=> out_valid_r, "idle event lost")
  `ASSERT_CLK(a_status_code, out_valid_r |-> out_r.status != 2'd3, "undefined status code")

endmodule

[rtl/cfcp_frame_check.sv]
// Frame store, write position, frame check and held box values.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cfcp_frame_check import cfcp_pkg::*; #(
  parameter int BufferLength = BUFFER_LENGTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  logic    kind,
  input  byte_t   rx_byte,
  output result_t result
);

  localparam int PosW = $clog2(BufferLength);

  byte_t           frame_r [FRAME_SIZE];
  byte_t           frame_nxt [FRAME_SIZE];
  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0]     held_x_r, held_y_r, held_w_r, held_l_r;
  logic [15:0]     held_x_nxt, held_y_nxt, held_w_nxt, held_l_nxt;
  logic [1:0]      status;
  byte_t           sum;

  // Checksum over bytes 1 to 8, kept to 8 bits
  always_comb begin
    sum = '0;
    for (int k = 1; k <= 8; k++) begin
      sum = sum + frame_r[k];
    end
  end

  // Frame check and status
  always_comb begin
    if (frame_r[0] != HEADER_MARK || frame_r[FRAME_SIZE-1] != TRAILER_MARK) begin
      status = STATUS_FRAMING;
    end else if (frame_r[9] != sum) begin
      status = STATUS_CHECKSUM;
    end else begin
      status = STATUS_OK;
    end
  end

  // Next state of the store, position and held values
  always_comb begin
    frame_nxt  = frame_r;
    pos_nxt    = pos_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    held_w_nxt = held_w_r;
    held_l_nxt = held_l_r;
    if (kind == KIND_BYTE) begin
      for (int i = 0; i < FRAME_SIZE; i++) begin
        if (pos_r == PosW'(i)) begin
          frame_nxt[i] = rx_byte;
        end
      end
      if (pos_r == PosW'(BufferLength - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PosW'(1);
      end
    end else begin
      pos_nxt = '0;
      if (status == STATUS_CHECKSUM) begin
        for (int i = 0; i < FRAME_SIZE; i++) begin
          frame_nxt[i] = '0;
        end
      end else if (status == STATUS_OK) begin
        held_x_nxt = {frame_r[1], frame_r[2]};
        held_y_nxt = {frame_r[3], frame_r[4]};
        held_w_nxt = {frame_r[5], frame_r[6]};
        held_l_nxt = {frame_r[7], frame_r[8]};
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FRAME_SIZE; i++) begin
        frame_r[i] <= '0;
      end
      pos_r    <= '0;
      held_x_r <= '0;
      held_y_r <= '0;
      held_w_r <= '0;
      held_l_r <= '0;
    end else if (step) begin
      frame_r  <= frame_nxt;
      pos_r    <= pos_nxt;
      held_x_r <= held_x_nxt;
      held_y_r <= held_y_nxt;
      held_w_r <= held_w_nxt;
      held_l_r <= held_l_nxt;
    end
  end

  // Result reports held values after this event's update
  assign result = '{status:     status,
                    x_value:    held_x_nxt,
                    y_value:    held_y_nxt,
                    box_width:  held_w_nxt,
                    box_length: held_l_nxt};

  `ASSERT_CLK(a_idle_resets_pos, step && kind == KIND_IDLE |=> pos_r == '0, "position not reset on idle")
  `ASSERT_CLK(a_bad_sum_clears, step && kind == KIND_IDLE && status == STATUS_CHECKSUM |=> frame_r[0] == '0 && frame_r[FRAME_SIZE-1] == '0, "store not cleared on bad checksum")
  `ASSERT_CLK(a_ok_latches_x, step && kind == KIND_IDLE && status == STATUS_OK |=> held_x_r == $past({frame_r[1], frame_r[2]}), "x not latched from good frame")

endmodule

[tb/sv/camera_frame_checksum_parser_tb.sv]
// Self-checking testbench of the camera frame checksum parser with a frame-tracking scoreboard.
`timescale 1ns / 1ps

module camera_frame_checksum_parser_tb;
  import cfcp_pkg::*;

  localparam int unsigned ITEM_TARGET = 1450;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned DRAIN_TAIL = 10;

  typedef enum {FAULT_NONE, FAULT_HEADER, FAULT_TRAILER, FAULT_SUM} frame_fault_e;

  // Tracks the stored frame and held box, and queues the status each idle event reports
  class frame_scoreboard;
    byte_t frame_mem[FRAME_SIZE];
    int unsigned write_pos;
    logic [15:0] held_x, held_y, held_width, held_length;
    result_t status_q[$];
    int unsigned error_count;

    function new();
      foreach (frame_mem[k]) frame_mem[k] = 8'h00;
      write_pos = 0;
      held_x = '0;
      held_y = '0;
      held_width = '0;
      held_length = '0;
      error_count = 0;
    endfunction

    function void note_input(logic kind, byte_t data);
      result_t res;
      byte_t sum;
      if (kind == KIND_BYTE) begin
        if (write_pos < FRAME_SIZE) frame_mem[write_pos] = data;
        write_pos = (write_pos + 1 >= BUFFER_LENGTH) ? 0 : write_pos + 1;
      end else begin
        sum = 8'h00;
        for (int k = 1; k <= 8; k++) sum += frame_mem[k];
        if (frame_mem[0] != HEADER_MARK || frame_mem[10] != TRAILER_MARK) begin
          res.status = STATUS_FRAMING;
        end else if (frame_mem[9] != sum) begin
          // checksum failure wipes the stored frame, held box stays
          res.status = STATUS_CHECKSUM;
          foreach (frame_mem[k]) frame_mem[k] = 8'h00;
        end else begin
          res.status = STATUS_OK;
          held_x = {frame_mem[1], frame_mem[2]};
          held_y = {frame_mem[3], frame_mem[4]};
          held_width = {frame_mem[5], frame_mem[6]};
          held_length = {frame_mem[7], frame_mem[8]};
        end
        res.x_value = held_x;
        res.y_value = held_y;
        res.box_width = held_width;
        res.box_length = held_length;
        status_q.push_back(res);
        write_pos = 0;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (status_q.size() == 0) begin
        $error("unexpected result transfer: status %0d x %h", got.status, got.x_value);
        error_count++;
        return;
      end
      want = status_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        error_count++;
      end
      if (got.x_value !== want.x_value) begin
        $error("x_value: expected %h, got %h", want.x_value, got.x_value);
        error_count++;
      end
      if (got.y_value !== want.y_value) begin
        $error("y_value: expected %h, got %h", want.y_value, got.y_value);
        error_count++;
      end
      if (got.box_width !== want.box_width) begin
        $error("box_width: expected %h, got %h", want.box_width, got.box_width);
        error_count++;
      end
      if (got.box_length !== want.box_length) begin
        $error("box_length: expected %h, got %h", want.box_length, got.box_length);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_kind;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [15:0] out_x_value;
  logic [15:0] out_y_value;
  logic [15:0] out_box_width;
  logic [15:0] out_box_length;

  frame_scoreboard sb = new();
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  bit steady = 1'b0;
  bit hold_request = 1'b0;

  camera_frame_checksum_parser dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_x_value(out_x_value),
    .out_y_value(out_y_value),
    .out_box_width(out_box_width),
    .out_box_length(out_box_length)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly random bytes, with the extremes well represented
  function automatic byte_t pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return byte_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One input transfer, preceded by a random gap unless in a steady stretch
  task automatic send_item(input logic kind, input byte_t data);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_rx_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(kind, data);
    items_sent++;
  endtask

  // Full 11-byte frame plus the idle event, with an optional fault
  task automatic send_frame(input byte_t body[8], input frame_fault_e fault);
    byte_t sum, head, tail;
    sum = 8'h00;
    foreach (body[k]) sum += body[k];
    head = HEADER_MARK;
    tail = TRAILER_MARK;
    case (fault)
      FAULT_HEADER: head ^= byte_t'($urandom_range(1, 255));
      FAULT_TRAILER: tail ^= byte_t'($urandom_range(1, 255));
      FAULT_SUM: sum ^= byte_t'($urandom_range(1, 255));
      default: ;
    endcase
    send_item(KIND_BYTE, head);
    foreach (body[k]) send_item(KIND_BYTE, body[k]);
    send_item(KIND_BYTE, sum);
    send_item(KIND_BYTE, tail);
    send_item(KIND_IDLE, pick_byte());
  endtask

  // Stop offering and wait for every outstanding status
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.status_q.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : receiver
    int unsigned gap;
    result_t got;
    out_stall <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        gap = steady ? 0 : $urandom_range(0, 15);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = {out_status, out_x_value, out_y_value, out_box_width, out_box_length};
      sb.check_result(got);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    byte_t body[8];
    int unsigned choice, len;
    bit hold_done, drain_done;
    frame_fault_e fault;
    hold_done = 1'b0;
    drain_done = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= KIND_BYTE;
    in_rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty buffer after reset reports a framing error
    send_item(KIND_IDLE, 8'hff);
    // good frame with all-ones payload
    foreach (body[k]) body[k] = 8'hff;
    send_frame(body, FAULT_NONE);
    // short burst: only the header, the rest is left over and still valid
    send_item(KIND_BYTE, HEADER_MARK);
    send_item(KIND_IDLE, 8'h00);
    // ten bytes with a wrong checksum, old trailer remains: clears the buffer
    send_item(KIND_BYTE, HEADER_MARK);
    repeat (8) send_item(KIND_BYTE, 8'h00);
    send_item(KIND_BYTE, 8'h01);
    send_item(KIND_IDLE, 8'h00);
    // cleared buffer fails framing
    send_item(KIND_IDLE, 8'h55);

    // Random: mostly well-formed frames, plus faults, odd bursts and noise
    while (items_sent < ITEM_TARGET) begin
      if (!hold_done && items_sent >= 400) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && items_sent >= 900) begin
        drain_results();
        drain_done = 1'b1;
      end else if ($urandom_range(0, 29) == 0) begin
        drain_results();
      end
      if ($urandom_range(0, 9) == 0) steady = !steady;
      foreach (body[k]) body[k] = pick_byte();
      choice = $urandom_range(0, 99);
      if (choice < 70) begin
        choice = $urandom_range(0, 99);
        if (choice < 65) fault = FAULT_NONE;
        else if (choice < 75) fault = FAULT_HEADER;
        else if (choice < 85) fault = FAULT_TRAILER;
        else fault = FAULT_SUM;
        send_frame(body, fault);
      end else if (choice < 78) begin
        // junk fills the whole buffer, then a frame after the wrap
        repeat (BUFFER_LENGTH) send_item(KIND_BYTE, pick_byte());
        send_frame(body, FAULT_NONE);
      end else if (choice < 86) begin
        // short burst over leftover bytes
        len = $urandom_range(0, 10);
        for (int i = 0; i < len; i++)
          send_item(KIND_BYTE, (i == 0 && $urandom_range(0, 1)) ? HEADER_MARK : pick_byte());
        send_item(KIND_IDLE, pick_byte());
      end else if (choice < 93) begin
        // long burst past the frame size, often wrapping
        len = $urandom_range(12, 40);
        repeat (len) send_item(KIND_BYTE, pick_byte());
        send_item(KIND_IDLE, pick_byte());
      end else begin
        repeat ($urandom_range(1, 6)) send_item(logic'($urandom_range(0, 1)), pick_byte());
      end
    end

    drain_results();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (sb.error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
